// ===== design/dro_pkg.sv =====
package dro_pkg;

   // input transaction opcodes
   typedef enum logic [1:0] {
      OP_UPDATE = 2'd0,
      OP_RESET  = 2'd1,
      OP_EDGE   = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INIT,
      ST_CORDIC,
      ST_ROUND,
      ST_MULT,
      ST_APPLY,
      ST_DONE
   } fsm_type;

   // register file
   localparam int  PADDR_W     = 3;
   localparam int  PDATA_W     = 32;
   localparam logic CSR_IDX_DPP = 1'b0;
   localparam int  DPP_W       = 24;
   localparam logic [DPP_W-1:0] DPP_RESET = 24'd65536;

   // field widths
   localparam int ACC_W_POS = 48;
   localparam int CNT_W     = 16;
   localparam int YAW_W     = 16;
   localparam int EDGE_W    = 8;

   // angle wrapping, hundredths of a degree
   localparam int YAW_EXT_W = 17;
   localparam logic signed [YAW_EXT_W-1:0] YAW_HALF = 17'sd18000;
   localparam logic signed [YAW_EXT_W-1:0] YAW_FULL = 17'sd36000;
   localparam logic signed [YAW_EXT_W-1:0] YAW_QTR  = 17'sd9000;

   // CORDIC, 30 fraction bits, angle unit 1/6553600 degree
   localparam int CORDIC_N = 24;
   localparam int IT_W     = 5;
   localparam int CX_W     = 34;
   localparam int CZ_W     = 32;
   localparam int Z_SHIFT  = 16;
   localparam logic signed [CX_W-1:0] CORDIC_GAIN = 34'sd652032874;

   // shared multiplier
   localparam int MUL_W   = 24;
   localparam int PROD_W  = 2 * MUL_W;
   localparam int S_W     = 40;
   localparam int SPLIT_W = 20;
   localparam int SUM_W   = 17;
   localparam int DM_W    = 32;
   localparam int LEN_SH  = 9;

   function automatic logic signed [CZ_W-1:0] atan_lut(input logic [IT_W-1:0] idx);
      logic signed [CZ_W-1:0] v;
      unique case (idx)
         5'd0:  v = 32'sd294912000;
         5'd1:  v = 32'sd174096719;
         5'd2:  v = 32'sd91987925;
         5'd3:  v = 32'sd46694507;
         5'd4:  v = 32'sd23437865;
         5'd5:  v = 32'sd11730358;
         5'd6:  v = 32'sd5866610;
         5'd7:  v = 32'sd2933484;
         5'd8:  v = 32'sd1466764;
         5'd9:  v = 32'sd733385;
         5'd10: v = 32'sd366693;
         5'd11: v = 32'sd183347;
         5'd12: v = 32'sd91673;
         5'd13: v = 32'sd45837;
         5'd14: v = 32'sd22918;
         5'd15: v = 32'sd11459;
         5'd16: v = 32'sd5730;
         5'd17: v = 32'sd2865;
         5'd18: v = 32'sd1432;
         5'd19: v = 32'sd716;
         5'd20: v = 32'sd358;
         5'd21: v = 32'sd179;
         5'd22: v = 32'sd90;
         5'd23: v = 32'sd45;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

// ===== design/dead_reckoning_odometry.sv =====
// Dead-reckoning odometry for a differential-drive vehicle. Each input
// transaction carries an opcode, the left and right encoder pulse counts of
// one tick and the IMU yaw (hundredths of a degree). An update tick scales
// the summed counts by distance_per_pulse (APB register at address 0, mm per
// pulse in unsigned Q8.16), rotates the centre step onto east/north with a
// CORDIC cosine and sine of the yaw, and adds the step length to the total
// and per-edge distances; all accumulators saturate. A reset opcode clears
// everything and loads the heading from yaw, an edge opcode clears the edge
// distance and bumps the 8-bit edge index. Every transaction returns one
// result holding the state after it. An update tick runs a setup step that
// also scales the counts, 24 CORDIC iterations of one shared add/shift
// unit, a round, the two projections of the 40-bit step on the one
// 24x24 multiplier, an accumulate, a result load and an idle; reset and
// edge opcodes skip to the accumulate. The result register is separate,
// so a new transaction is taken while an older result waits on rsp_ready.
module dead_reckoning_odometry
   import dro_pkg::*;
#(
   parameter int TRIG_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   // request channel
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [1:0]                   req_op,
   input  logic signed [CNT_W-1:0]      req_left_count,
   input  logic signed [CNT_W-1:0]      req_right_count,
   input  logic signed [YAW_W-1:0]      req_yaw,
   // response channel
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [ACC_W_POS-1:0]  rsp_pos_x,
   output logic signed [ACC_W_POS-1:0]  rsp_pos_y,
   output logic signed [YAW_W-1:0]      rsp_heading,
   output logic [ACC_W_POS-1:0]         rsp_total_distance,
   output logic [ACC_W_POS-1:0]         rsp_edge_distance,
   output logic [EDGE_W-1:0]            rsp_edge_index,
   // APB register port
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [PADDR_W-1:0]           paddr,
   input  logic [PDATA_W-1:0]           pwdata,
   output logic [PDATA_W-1:0]           prdata,
   output logic                         pready
);

   // fixed-point scaling derived from trig precision
   localparam int TF      = TRIG_BITS - 1;        // trig fraction bits
   localparam int SH_TRIG = 30 - TF;              // CORDIC -> trig rounding shift
   localparam int SH_MUL  = 9 + TF;               // step projection shift
   localparam int ACC_W   = S_W + TF;             // |s| * |trig|
   localparam logic signed [CX_W-1:0] TRIG_HALF = CX_W'(64'd1 << (SH_TRIG - 1));
   localparam logic signed [CX_W-1:0] TRIG_LIM  = CX_W'((64'd1 << TF) - 64'd1);
   localparam logic [ACC_W:0] MUL_HALF = (ACC_W+1)'(64'd1 << (SH_MUL - 1));
   localparam logic signed [TRIG_BITS-1:0] TRIG_MIN = {1'b1, {TF{1'b0}}};
   localparam logic signed [ACC_W_POS:0] SMAX = {2'b00, {(ACC_W_POS-1){1'b1}}};
   localparam logic signed [ACC_W_POS:0] SMIN = {2'b11, {(ACC_W_POS-1){1'b0}}};

   // sequencer
   fsm_type state_ff, state_in;
   logic [IT_W-1:0] it_ff, it_in;
   logic [2:0]      mstep_ff, mstep_in;   // {sin select, phase}

   // captured transaction
   logic [1:0]                op_ff;
   logic signed [CNT_W-1:0]   left_ff, right_ff;
   logic signed [YAW_W-1:0]   yaw_ff;
   logic                      take;

   // config
   logic [DPP_W-1:0] dpp_ff, dpp_in;

   // datapath
   logic [S_W-1:0]              s_mag_ff, s_mag_in;
   logic                        s_neg_ff, s_neg_in;
   logic signed [CX_W-1:0]      cx_ff, cx_in, cy_ff, cy_in;
   logic signed [CZ_W-1:0]      cz_ff, cz_in;
   logic                        tneg_ff, tneg_in;
   logic signed [TRIG_BITS-1:0] cos_ff, cos_in, sin_ff, sin_in;
   logic [PROD_W-1:0]           prod_ff, prod_in;
   logic [ACC_W-1:0]            acc_ff, acc_in;
   logic [DM_W-1:0]             dxm_ff, dxm_in, dym_ff, dym_in, len_ff, len_in;

   // odometry state
   logic signed [ACC_W_POS-1:0] x_acc_ff, x_acc_in, y_acc_ff, y_acc_in;
   logic signed [YAW_W-1:0]     head_ff, head_in;
   logic [ACC_W_POS-1:0]        tot_ff, tot_in, edge_ff, edge_in;
   logic [EDGE_W-1:0]           ecnt_ff, ecnt_in;

   // result register
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_load;
   logic signed [ACC_W_POS-1:0] rsp_x_ff, rsp_y_ff;
   logic signed [YAW_W-1:0]     rsp_head_ff;
   logic [ACC_W_POS-1:0]        rsp_tot_ff, rsp_edge_ff;
   logic [EDGE_W-1:0]           rsp_ecnt_ff;

   // shared multiplier
   logic [MUL_W-1:0]  mul_a, mul_b;
   logic [PROD_W-1:0] mul_p;

   // combinational helpers
   logic signed [SUM_W-1:0]     cnt_sum;
   logic [SUM_W-1:0]            cnt_mag;
   logic signed [YAW_EXT_W-1:0] yaw_wrap, yaw_fold;
   logic                        yaw_neg;
   logic signed [CX_W-1:0]      sh_x, sh_y, xn, yn, xr, yr;
   logic signed [TRIG_BITS-1:0] trig_sel;
   logic [TF-1:0]               trig_mag;
   logic [TRIG_BITS-1:0]        trig_abs;
   logic [SPLIT_W-1:0]          s_chunk;
   logic [SPLIT_W+PROD_W-1:0]   prod_wide;
   logic [ACC_W:0]              dsum, dshift;
   logic [S_W:0]                len_sum, len_shift;
   logic signed [DM_W:0]        dx_s, dy_s;
   logic                        csr_wr;

   function automatic logic signed [CX_W-1:0] trig_clamp(input logic signed [CX_W-1:0] v);
      logic signed [CX_W-1:0] r;
      r = v;
      if (v > TRIG_LIM) r = TRIG_LIM;
      else if (v < -TRIG_LIM) r = -TRIG_LIM;
      return r;
   endfunction

   function automatic logic signed [ACC_W_POS-1:0] sat_add_s(
      input logic signed [ACC_W_POS-1:0] a, input logic signed [DM_W:0] d);
      logic signed [ACC_W_POS:0] t;
      logic signed [ACC_W_POS-1:0] r;
      t = (ACC_W_POS+1)'(a) + (ACC_W_POS+1)'(d);
      if (t > SMAX) r = SMAX[ACC_W_POS-1:0];
      else if (t < SMIN) r = SMIN[ACC_W_POS-1:0];
      else r = t[ACC_W_POS-1:0];
      return r;
   endfunction

   function automatic logic [ACC_W_POS-1:0] sat_add_u(
      input logic [ACC_W_POS-1:0] a, input logic [DM_W-1:0] d);
      logic [ACC_W_POS:0] t;
      logic [ACC_W_POS-1:0] r;
      t = {1'b0, a} + (ACC_W_POS+1)'(d);
      r = t[ACC_W_POS] ? {ACC_W_POS{1'b1}} : t[ACC_W_POS-1:0];
      return r;
   endfunction

   // ------------------------------------------------------------------
   // APB: single register, zero wait states
   // ------------------------------------------------------------------
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready;
   assign prdata = (paddr[PADDR_W-1] == CSR_IDX_DPP) ? PDATA_W'(dpp_ff) : '0;

   always_comb begin
      dpp_in = dpp_ff;
      if (csr_wr && paddr[PADDR_W-1] == CSR_IDX_DPP) begin
         dpp_in = pwdata[DPP_W-1:0];
      end
   end

   // ------------------------------------------------------------------
   // next state
   // ------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = (req_op == OP_UPDATE) ? ST_INIT : ST_APPLY;
            end
         end
         ST_INIT:   state_in = ST_CORDIC;
         ST_CORDIC: begin
            if (it_ff == IT_W'(CORDIC_N - 1)) state_in = ST_ROUND;
         end
         ST_ROUND:  state_in = ST_MULT;
         ST_MULT: begin
            if (mstep_ff == 3'd7) state_in = ST_APPLY;
         end
         ST_APPLY:  state_in = ST_DONE;
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) state_in = ST_IDLE;
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // ------------------------------------------------------------------
   // handshake outputs
   // ------------------------------------------------------------------
   always_comb begin
      req_ready    = (state_ff == ST_IDLE);
      take         = req_valid && req_ready;
      rsp_load     = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);
      rsp_valid_in = rsp_load ? 1'b1 : (rsp_valid_ff && !rsp_ready);
   end

   // ------------------------------------------------------------------
   // datapath
   // ------------------------------------------------------------------
   // count sum and yaw folding for setup
   always_comb begin
      cnt_sum = SUM_W'(left_ff) + SUM_W'(right_ff);
      cnt_mag = cnt_sum[SUM_W-1] ? SUM_W'(-cnt_sum) : SUM_W'(cnt_sum);

      yaw_wrap = YAW_EXT_W'(yaw_ff);
      if (yaw_wrap >= YAW_HALF) yaw_wrap = yaw_wrap - YAW_FULL;
      else if (yaw_wrap < -YAW_HALF) yaw_wrap = yaw_wrap + YAW_FULL;

      yaw_fold = yaw_wrap;
      yaw_neg  = 1'b0;
      if (yaw_wrap > YAW_QTR) begin
         yaw_fold = yaw_wrap - YAW_HALF;
         yaw_neg  = 1'b1;
      end else if (yaw_wrap < -YAW_QTR) begin
         yaw_fold = yaw_wrap + YAW_HALF;
         yaw_neg  = 1'b1;
      end
   end

   // CORDIC shifter and final rounding
   always_comb begin
      sh_x = cy_ff >>> it_ff;
      sh_y = cx_ff >>> it_ff;
      xn   = tneg_ff ? -cx_ff : cx_ff;
      yn   = tneg_ff ? -cy_ff : cy_ff;
      xr   = trig_clamp((xn + TRIG_HALF) >>> SH_TRIG);
      yr   = trig_clamp((yn + TRIG_HALF) >>> SH_TRIG);
   end

   // multiplier operand select
   always_comb begin
      trig_sel  = mstep_ff[2] ? sin_ff : cos_ff;
      trig_abs  = trig_sel[TRIG_BITS-1] ? TRIG_BITS'(-trig_sel) : TRIG_BITS'(trig_sel);
      trig_mag  = trig_abs[TF-1:0];
      s_chunk   = mstep_ff[0] ? s_mag_ff[S_W-1:SPLIT_W] : s_mag_ff[SPLIT_W-1:0];
      if (state_ff == ST_INIT) begin
         mul_a = dpp_ff;
         mul_b = MUL_W'(cnt_mag);
      end else begin
         mul_a = MUL_W'(trig_mag);
         mul_b = MUL_W'(s_chunk);
      end
      mul_p     = mul_a * mul_b;
      prod_wide = {prod_ff, {SPLIT_W{1'b0}}};
      dsum      = {1'b0, acc_ff} + MUL_HALF;
      dshift    = dsum >> SH_MUL;
      len_sum   = {1'b0, s_mag_ff} + (S_W+1)'(256);
      len_shift = len_sum >> LEN_SH;
      dx_s      = (s_neg_ff ^ cos_ff[TRIG_BITS-1]) ? -$signed({1'b0, dxm_ff})
                                                   :  $signed({1'b0, dxm_ff});
      dy_s      = (s_neg_ff ^ sin_ff[TRIG_BITS-1]) ? -$signed({1'b0, dym_ff})
                                                   :  $signed({1'b0, dym_ff});
   end

   always_comb begin
      it_in    = it_ff;
      mstep_in = mstep_ff;
      s_mag_in = s_mag_ff;
      s_neg_in = s_neg_ff;
      cx_in    = cx_ff;
      cy_in    = cy_ff;
      cz_in    = cz_ff;
      tneg_in  = tneg_ff;
      cos_in   = cos_ff;
      sin_in   = sin_ff;
      prod_in  = prod_ff;
      acc_in   = acc_ff;
      dxm_in   = dxm_ff;
      dym_in   = dym_ff;
      len_in   = len_ff;
      x_acc_in = x_acc_ff;
      y_acc_in = y_acc_ff;
      head_in  = head_ff;
      tot_in   = tot_ff;
      edge_in  = edge_ff;
      ecnt_in  = ecnt_ff;

      unique case (state_ff)
         ST_INIT: begin
            s_mag_in = mul_p[S_W-1:0];
            s_neg_in = cnt_sum[SUM_W-1];
            cx_in    = CORDIC_GAIN;
            cy_in    = '0;
            cz_in    = CZ_W'(yaw_fold) <<< Z_SHIFT;
            tneg_in  = yaw_neg;
            it_in    = '0;
         end
         ST_CORDIC: begin
            if (cz_ff >= 0) begin
               cx_in = cx_ff - sh_x;
               cy_in = cy_ff + sh_y;
               cz_in = cz_ff - atan_lut(it_ff);
            end else begin
               cx_in = cx_ff + sh_x;
               cy_in = cy_ff - sh_y;
               cz_in = cz_ff + atan_lut(it_ff);
            end
            it_in = it_ff + 1'b1;
         end
         ST_ROUND: begin
            cos_in   = xr[TRIG_BITS-1:0];
            sin_in   = yr[TRIG_BITS-1:0];
            len_in   = len_shift[DM_W-1:0];
            mstep_in = '0;
         end
         ST_MULT: begin
            unique case (mstep_ff[1:0])
               2'd0: prod_in = mul_p;
               2'd1: begin
                  prod_in = mul_p;
                  acc_in  = ACC_W'(prod_ff);
               end
               2'd2: acc_in = acc_ff + prod_wide[ACC_W-1:0];
               2'd3: begin
                  if (mstep_ff[2]) dym_in = dshift[DM_W-1:0];
                  else             dxm_in = dshift[DM_W-1:0];
               end
               default: ;
            endcase
            mstep_in = mstep_ff + 1'b1;
         end
         ST_APPLY: begin
            unique case (op_ff)
               OP_UPDATE: begin
                  head_in  = yaw_ff;
                  x_acc_in = sat_add_s(x_acc_ff, dx_s);
                  y_acc_in = sat_add_s(y_acc_ff, dy_s);
                  tot_in   = sat_add_u(tot_ff, len_ff);
                  edge_in  = sat_add_u(edge_ff, len_ff);
               end
               OP_RESET: begin
                  head_in  = yaw_ff;
                  x_acc_in = '0;
                  y_acc_in = '0;
                  tot_in   = '0;
                  edge_in  = '0;
                  ecnt_in  = '0;
               end
               OP_EDGE: begin
                  edge_in = '0;
                  ecnt_in = ecnt_ff + 1'b1;
               end
               default: ;  // unused opcode leaves state alone
            endcase
         end
         default: ;
      endcase
   end

   // ------------------------------------------------------------------
   // registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         it_ff        <= '0;
         mstep_ff     <= '0;
         dpp_ff       <= DPP_RESET;
         x_acc_ff     <= '0;
         y_acc_ff     <= '0;
         head_ff      <= '0;
         tot_ff       <= '0;
         edge_ff      <= '0;
         ecnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         it_ff        <= it_in;
         mstep_ff     <= mstep_in;
         dpp_ff       <= dpp_in;
         x_acc_ff     <= x_acc_in;
         y_acc_ff     <= y_acc_in;
         head_ff      <= head_in;
         tot_ff       <= tot_in;
         edge_ff      <= edge_in;
         ecnt_ff      <= ecnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         op_ff    <= req_op;
         left_ff  <= req_left_count;
         right_ff <= req_right_count;
         yaw_ff   <= req_yaw;
      end
      s_mag_ff <= s_mag_in;
      s_neg_ff <= s_neg_in;
      cx_ff    <= cx_in;
      cy_ff    <= cy_in;
      cz_ff    <= cz_in;
      tneg_ff  <= tneg_in;
      cos_ff   <= cos_in;
      sin_ff   <= sin_in;
      prod_ff  <= prod_in;
      acc_ff   <= acc_in;
      dxm_ff   <= dxm_in;
      dym_ff   <= dym_in;
      len_ff   <= len_in;
      if (rsp_load) begin
         rsp_x_ff    <= x_acc_ff;
         rsp_y_ff    <= y_acc_ff;
         rsp_head_ff <= head_ff;
         rsp_tot_ff  <= tot_ff;
         rsp_edge_ff <= edge_ff;
         rsp_ecnt_ff <= ecnt_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_pos_x          = rsp_x_ff;
   assign rsp_pos_y          = rsp_y_ff;
   assign rsp_heading        = rsp_head_ff;
   assign rsp_total_distance = rsp_tot_ff;
   assign rsp_edge_distance  = rsp_edge_ff;
   assign rsp_edge_index     = rsp_ecnt_ff;

   // ------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------
   a_cordic_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CORDIC && state_in == ST_ROUND) |-> (it_ff == IT_W'(CORDIC_N - 1)))
      else $error("CORDIC left before last iteration");

   a_trig_clamp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MULT) |-> (cos_ff != TRIG_MIN && sin_ff != TRIG_MIN))
      else $error("trig value outside clamp range");

   a_skip_trig: assert property (@(posedge clock) disable iff (reset)
      (take && req_op != OP_UPDATE) |=> (state_ff == ST_APPLY))
      else $error("non-update transaction did not go straight to apply");

   a_acc_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_APPLY) |=> ($stable(x_acc_ff) && $stable(tot_ff) && $stable(ecnt_ff)))
      else $error("odometry state changed outside apply");

   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("response raised without a finished transaction");

endmodule

// ===== tb/odometry_checker.sv =====
`timescale 1ns / 1ps

module odometry_checker
   import dro_pkg::*;
#(
   parameter int TRIG_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_ready,
   input  logic [1:0]                  req_op,
   input  logic signed [CNT_W-1:0]     req_left_count,
   input  logic signed [CNT_W-1:0]     req_right_count,
   input  logic signed [YAW_W-1:0]     req_yaw,
   input  logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  logic signed [ACC_W_POS-1:0] rsp_pos_x,
   input  logic signed [ACC_W_POS-1:0] rsp_pos_y,
   input  logic signed [YAW_W-1:0]     rsp_heading,
   input  logic [ACC_W_POS-1:0]        rsp_total_distance,
   input  logic [ACC_W_POS-1:0]        rsp_edge_distance,
   input  logic [EDGE_W-1:0]           rsp_edge_index,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [PADDR_W-1:0]          paddr,
   input  logic [PDATA_W-1:0]          pwdata,
   input  logic                        pready,
   output int                          failures,
   output int                          pending
);

   localparam int     FRAC      = TRIG_BITS - 1;
   localparam longint POS_MAX   = 64'sh0000_7FFF_FFFF_FFFF;
   localparam longint POS_MIN   = -POS_MAX - 1;
   localparam longint DIST_MAX  = 64'sh0000_FFFF_FFFF_FFFF;
   localparam int     N_FIELDS  = 6;
   localparam int     REPORT_MAX = 10;

   typedef struct {
      logic signed [ACC_W_POS-1:0] pos_x;
      logic signed [ACC_W_POS-1:0] pos_y;
      logic signed [YAW_W-1:0]     heading;
      logic [ACC_W_POS-1:0]        total_distance;
      logic [ACC_W_POS-1:0]        edge_distance;
      logic [EDGE_W-1:0]           edge_index;
   } pose_type;

   // arctan(2^-i) in 1/6553600 degree
   longint atan_step [0:CORDIC_N-1] = '{
      294912000, 174096719, 91987925, 46694507, 23437865,
      11730358, 5866610, 2933484, 1466764, 733385, 366693,
      183347, 91673, 45837, 22918, 11459, 5730, 2865,
      1432, 716, 358, 179, 90, 45
   };

   string field_name [0:N_FIELDS-1] = '{
      "pos_x", "pos_y", "heading", "total_distance", "edge_distance", "edge_index"
   };

   logic [DPP_W-1:0]        pulse_scale;
   longint                  east_mm;
   longint                  north_mm;
   logic signed [YAW_W-1:0] heading_now;
   longint                  path_total;
   longint                  path_edge;
   logic [EDGE_W-1:0]       edge_no;
   pose_type                pose_q [$];
   int                      reported;
   int                      rsp_seen;

   // CORDIC cos/sin of a yaw, FRAC fraction bits
   function automatic void yaw_to_cos_sin(input logic signed [YAW_W-1:0] yaw,
                                          output longint c, output longint s);
      longint w, x, y, z, xs, ys, lim;
      bit     flip;
      int     sh, i;
      w    = ((longint'(yaw) + 18000) % 36000 + 36000) % 36000 - 18000;
      flip = 1'b0;
      x    = CORDIC_GAIN;
      y    = 0;
      sh   = 30 - FRAC;
      lim  = (longint'(1) << FRAC) - 1;
      if (w > 9000) begin
         w -= 18000;
         flip = 1'b1;
      end else if (w < -9000) begin
         w += 18000;
         flip = 1'b1;
      end
      z = w * 65536;
      for (i = 0; i < CORDIC_N; i++) begin
         xs = y >>> i;
         ys = x >>> i;
         if (z >= 0) begin
            x -= xs;
            y += ys;
            z -= atan_step[i];
         end else begin
            x += xs;
            y -= ys;
            z += atan_step[i];
         end
      end
      if (flip) begin
         x = -x;
         y = -y;
      end
      x = (x + (longint'(1) << (sh - 1))) >>> sh;
      y = (y + (longint'(1) << (sh - 1))) >>> sh;
      c = (x > lim) ? lim : (x < -lim) ? -lim : x;
      s = (y > lim) ? lim : (y < -lim) ? -lim : y;
   endfunction

   // |a*b| / 2^sh rounded half away from zero, sign restored
   function automatic longint scale_round(input longint a, input longint b, input int sh);
      longint unsigned ma, mb, p;
      longint          r;
      ma = (a < 0) ? -a : a;
      mb = (b < 0) ? -b : b;
      p  = ma * mb;
      r  = longint'((p + (64'd1 << (sh - 1))) >> sh);
      return ((a < 0) != (b < 0)) ? -r : r;
   endfunction

   function automatic longint clamp_pos(input longint v);
      return (v > POS_MAX) ? POS_MAX : (v < POS_MIN) ? POS_MIN : v;
   endfunction

   function automatic longint clamp_dist(input longint v);
      return (v > DIST_MAX) ? DIST_MAX : v;
   endfunction

   // apply one transaction to the predicted odometry, return the pose after it
   function automatic pose_type integrate(input logic [1:0] op,
                                          input logic signed [CNT_W-1:0] lc,
                                          input logic signed [CNT_W-1:0] rc,
                                          input logic signed [YAW_W-1:0] yaw);
      longint   twice_step, c, s, len;
      pose_type p;
      case (op)
         OP_UPDATE: begin
            twice_step = longint'(lc) * longint'(pulse_scale)
                       + longint'(rc) * longint'(pulse_scale);
            heading_now = yaw;
            yaw_to_cos_sin(yaw, c, s);
            east_mm  = clamp_pos(east_mm + scale_round(twice_step, c, LEN_SH + FRAC));
            north_mm = clamp_pos(north_mm + scale_round(twice_step, s, LEN_SH + FRAC));
            len = scale_round((twice_step < 0) ? -twice_step : twice_step, 1, LEN_SH);
            path_total = clamp_dist(path_total + len);
            path_edge  = clamp_dist(path_edge + len);
         end
         OP_RESET: begin
            east_mm     = 0;
            north_mm    = 0;
            heading_now = yaw;
            path_total  = 0;
            path_edge   = 0;
            edge_no     = '0;
         end
         OP_EDGE: begin
            path_edge = 0;
            edge_no   = edge_no + 1'b1;
         end
         default: ;
      endcase
      p.pos_x          = east_mm[ACC_W_POS-1:0];
      p.pos_y          = north_mm[ACC_W_POS-1:0];
      p.heading        = heading_now;
      p.total_distance = path_total[ACC_W_POS-1:0];
      p.edge_distance  = path_edge[ACC_W_POS-1:0];
      p.edge_index     = edge_no;
      return p;
   endfunction

   task automatic check_pose();
      pose_type             p;
      logic [ACC_W_POS-1:0] want [0:N_FIELDS-1];
      logic [ACC_W_POS-1:0] got  [0:N_FIELDS-1];
      int                   k;
      if (pose_q.size() == 0) begin
         failures++;
         if (reported < REPORT_MAX)
            $display("result %0d arrived with nothing outstanding", rsp_seen);
         reported++;
         return;
      end
      p = pose_q.pop_front();
      want = '{p.pos_x, p.pos_y, ACC_W_POS'(p.heading), p.total_distance,
               p.edge_distance, ACC_W_POS'(p.edge_index)};
      got  = '{rsp_pos_x, rsp_pos_y, ACC_W_POS'(rsp_heading), rsp_total_distance,
               rsp_edge_distance, ACC_W_POS'(rsp_edge_index)};
      for (k = 0; k < N_FIELDS; k++) begin
         if (got[k] !== want[k]) begin
            failures++;
            if (reported < REPORT_MAX)
               $display("result %0d %s: expected %h, got %h",
                        rsp_seen, field_name[k], want[k], got[k]);
            reported++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         pulse_scale  = DPP_RESET;
         east_mm      = 0;
         north_mm     = 0;
         heading_now  = '0;
         path_total   = 0;
         path_edge    = 0;
         edge_no      = '0;
         reported     = 0;
         rsp_seen     = 0;
         failures     = 0;
         pose_q.delete();
      end else begin
         if (psel && penable && pwrite && pready && paddr[PADDR_W-1:2] == CSR_IDX_DPP)
            pulse_scale = pwdata[DPP_W-1:0];
         // the response leaving now belongs to an older transaction
         if (rsp_valid && rsp_ready) begin
            check_pose();
            rsp_seen++;
         end
         if (req_valid && req_ready)
            pose_q.push_back(integrate(req_op, req_left_count, req_right_count, req_yaw));
      end
      pending = pose_q.size();
   end

endmodule

// ===== tb/dead_reckoning_odometry_tb.sv =====
`timescale 1ns / 1ps

module dead_reckoning_odometry_tb;
   import dro_pkg::*;

   localparam int TRIG_BITS = 16;

   // spare opcode, must leave the state untouched
   localparam logic [1:0] OP_SPARE = 2'd3;

   // register map: distance_per_pulse at 0, next word is unmapped
   localparam logic [PADDR_W-1:0] DPP_ADDR   = {CSR_IDX_DPP, 2'b00};
   localparam logic [PADDR_W-1:0] SPARE_ADDR = 3'd4;

   localparam int N_PHASES     = 5;
   localparam int EDGE_PHASE   = 3;   // edge-heavy phase, wraps the edge index
   localparam int PHASE_ITEMS  = 190;
   localparam int EDGE_ITEMS   = 300;
   localparam int DRAIN_CYCLES = 48;
   localparam int HOLD_AT      = 250; // responses seen before the long stall
   localparam int HOLD_CYCLES  = 400;
   localparam int TIMEOUT_NS   = 4_000_000;

   logic clock = 1'b0;
   logic reset;

   logic                        req_valid;
   logic                        req_ready;
   logic [1:0]                  req_op;
   logic signed [CNT_W-1:0]     req_left_count;
   logic signed [CNT_W-1:0]     req_right_count;
   logic signed [YAW_W-1:0]     req_yaw;

   logic                        rsp_valid;
   logic                        rsp_ready;
   logic signed [ACC_W_POS-1:0] rsp_pos_x;
   logic signed [ACC_W_POS-1:0] rsp_pos_y;
   logic signed [YAW_W-1:0]     rsp_heading;
   logic [ACC_W_POS-1:0]        rsp_total_distance;
   logic [ACC_W_POS-1:0]        rsp_edge_distance;
   logic [EDGE_W-1:0]           rsp_edge_index;

   logic                        psel;
   logic                        penable;
   logic                        pwrite;
   logic [PADDR_W-1:0]          paddr;
   logic [PDATA_W-1:0]          pwdata;
   logic [PDATA_W-1:0]          prdata;
   logic                        pready;

   int failures;
   int pending;
   bit quiet = 1'b0;   // set for the last phase: no idling on either side

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   dead_reckoning_odometry #(
      .TRIG_BITS (TRIG_BITS)
   ) uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_op             (req_op),
      .req_left_count     (req_left_count),
      .req_right_count    (req_right_count),
      .req_yaw            (req_yaw),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_pos_x          (rsp_pos_x),
      .rsp_pos_y          (rsp_pos_y),
      .rsp_heading        (rsp_heading),
      .rsp_total_distance (rsp_total_distance),
      .rsp_edge_distance  (rsp_edge_distance),
      .rsp_edge_index     (rsp_edge_index),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready)
   );

   odometry_checker #(
      .TRIG_BITS (TRIG_BITS)
   ) odo_check (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_op             (req_op),
      .req_left_count     (req_left_count),
      .req_right_count    (req_right_count),
      .req_yaw            (req_yaw),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_pos_x          (rsp_pos_x),
      .rsp_pos_y          (rsp_pos_y),
      .rsp_heading        (rsp_heading),
      .rsp_total_distance (rsp_total_distance),
      .rsp_edge_distance  (rsp_edge_distance),
      .rsp_edge_index     (rsp_edge_index),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .pready             (pready),
      .failures           (failures),
      .pending            (pending)
   );

   // ---------------------------------------------------------------
   // Random field generators
   // ---------------------------------------------------------------

   // encoder counts: mostly slow driving, some full-range, some rails
   function automatic logic signed [CNT_W-1:0] draw_count();
      logic signed [CNT_W-1:0] v;
      case ($urandom_range(0, 11))
         0:       v = 16'sh7FFF;
         1:       v = 16'sh8000;
         2, 3, 4: v = CNT_W'($urandom);
         default: v = CNT_W'($urandom_range(0, 1200) - 600);
      endcase
      return v;
   endfunction

   // yaw: mostly legal heading, sometimes raw 16-bit garbage or a quadrant seam
   function automatic logic signed [YAW_W-1:0] draw_yaw();
      logic signed [YAW_W-1:0] v;
      case ($urandom_range(0, 9))
         0: v = YAW_W'($urandom);
         1: begin
            case ($urandom_range(0, 7))
               0:       v = 18000;
               1:       v = -18000;
               2:       v = 9000;
               3:       v = -9000;
               4:       v = 18001;
               5:       v = -18001;
               6:       v = 0;
               default: v = 27000;
            endcase
         end
         default: v = YAW_W'($urandom_range(0, 36000) - 18000);
      endcase
      return v;
   endfunction

   // opcode mix: updates dominate; edge-heavy phase pushes the index past 255
   function automatic logic [1:0] draw_op(input bit edge_heavy);
      int roll;
      roll = $urandom_range(0, 99);
      if (edge_heavy)
         return (roll < 90) ? OP_EDGE : OP_UPDATE;
      if (roll < 3)
         return OP_RESET;
      if (roll < 13)
         return OP_EDGE;
      if (roll < 14)
         return OP_SPARE;
      return OP_UPDATE;
   endfunction

   // ---------------------------------------------------------------
   // Request driver. Payload changes only at the falling edge; the
   // transaction is done once valid and ready meet at a rising edge.
   // ---------------------------------------------------------------
   bit send_calm = 1'b0;

   task automatic offer(input logic [1:0] op,
                        input logic signed [CNT_W-1:0] lc,
                        input logic signed [CNT_W-1:0] rc,
                        input logic signed [YAW_W-1:0] yaw);
      int gap;
      @(negedge clock);
      if ($urandom_range(0, 39) == 0)
         send_calm = !send_calm;
      // idle burst before this transaction; valid drops here, rises later
      if (!quiet && !send_calm && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 12);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_op          <= op;
      req_left_count  <= lc;
      req_right_count <= rc;
      req_yaw         <= yaw;
      do @(posedge clock); while (!req_ready);
   endtask

   // stop offering, wait for every response, then let the datapath go quiet
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // APB write: setup cycle, then access cycle until pready
   task automatic csr_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // ---------------------------------------------------------------
   // Response sink: random stall bursts, calm stretches, and one long
   // hold-off so the result register fills and req_ready drops.
   // ---------------------------------------------------------------
   initial begin : result_sink
      int stall;
      int taken;
      bit calm;
      bit held;
      stall = 0;
      taken = 0;
      calm  = 1'b0;
      held  = 1'b0;
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            stall--;
         end else if (!quiet && !held && taken >= HOLD_AT) begin
            held = 1'b1;
            stall = HOLD_CYCLES - 1;
            rsp_ready <= 1'b0;
         end else if (!quiet && !calm && $urandom_range(0, 5) == 0) begin
            stall = $urandom_range(1, 12) - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
         if ($urandom_range(0, 59) == 0)
            calm = !calm;
         @(posedge clock);
         if (rsp_valid && rsp_ready)
            taken++;
         @(negedge clock);
      end
   end

   // ---------------------------------------------------------------
   // Stimulus and verdict
   // ---------------------------------------------------------------
   initial begin : stimulus
      int phase;
      int n_items;
      logic [PDATA_W-1:0] dpp_word;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_op          = OP_UPDATE;
      req_left_count  = '0;
      req_right_count = '0;
      req_yaw         = '0;
      psel            = 1'b0;
      penable         = 1'b0;
      pwrite          = 1'b0;
      paddr           = '0;
      pwdata          = '0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      // Directed part, distance_per_pulse still at its reset value.
      offer(OP_UPDATE, 0, 0, 0);
      offer(OP_UPDATE, 16'sh7FFF, 16'sh7FFF, 0);
      offer(OP_UPDATE, 16'sh8000, 16'sh8000, 18000);
      offer(OP_UPDATE, 16'sh7FFF, 16'sh8000, -18000);
      offer(OP_UPDATE, 100, 200, 9000);
      offer(OP_UPDATE, 100, 200, -9000);
      offer(OP_UPDATE, 500, 500, 4500);
      offer(OP_UPDATE, 1, 0, 1);              // half-pulse step
      // yaw outside the legal heading range: trig angle wraps, heading is raw
      offer(OP_UPDATE, 1, 2, 16'sh7FFF);
      offer(OP_UPDATE, -3, 7, 16'sh8000);
      offer(OP_UPDATE, 250, -250, 18001);
      offer(OP_UPDATE, 1000, 900, -18001);
      // new edge; counts carry junk that must be ignored
      offer(OP_EDGE, 16'sh5555, 16'shAAAA, 16'sh5555);
      offer(OP_UPDATE, 40, 40, 13500);
      // spare opcode: no state change, still one response
      offer(OP_SPARE, 16'shAAAA, 16'sh5555, 16'shAAAA);
      // full reset picks up the yaw as heading
      offer(OP_RESET, 16'sh7FFF, 16'sh8000, 12345);
      offer(OP_UPDATE, 10, 10, 27000);
      offer(OP_EDGE, 0, 0, 0);
      offer(OP_UPDATE, 16'sh5555, 16'shAAAA, -4500);
      offer(OP_RESET, 0, 0, -18000);

      // Random phases, each with its own scale; last one runs without idling.
      for (phase = 0; phase < N_PHASES; phase++) begin
         settle();
         case (phase)
            0: dpp_word = {8'hA5, 24'hFF_FFFF};   // top of range, junk upper byte
            1: dpp_word = {8'h5A, 24'h00_0000};   // zero travel per pulse
            2: dpp_word = $urandom;
            3: dpp_word = $urandom_range(1, 70000);
            default: dpp_word = {8'($urandom_range(0, 255)), 24'h00_0001};
         endcase
         csr_write(DPP_ADDR, dpp_word);
         if (phase == 1)
            csr_write(SPARE_ADDR, $urandom);      // unmapped word, must be ignored
         if (phase == 0) begin
            // extremes once more at the largest scale
            offer(OP_UPDATE, 16'sh7FFF, 16'sh7FFF, 0);
            offer(OP_UPDATE, 16'sh8000, 16'sh8000, -13500);
         end
         if (phase == N_PHASES - 1)
            quiet = 1'b1;
         n_items = (phase == EDGE_PHASE) ? EDGE_ITEMS : PHASE_ITEMS;
         repeat (n_items)
            offer(draw_op(phase == EDGE_PHASE), draw_count(), draw_count(), draw_yaw());
      end

      settle();
      if (failures == 0 && pending == 0) begin
         $display("dead_reckoning_odometry: match");
      end else begin
         $display("dead_reckoning_odometry: mismatch");
      end
      $finish;
   end

   // hard stop in case a handshake never completes
   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("dead_reckoning_odometry: mismatch");
      $finish;
   end

endmodule

// ===== filelist.f =====
design/dro_pkg.sv
design/dead_reckoning_odometry.sv
tb/odometry_checker.sv
tb/dead_reckoning_odometry_tb.sv
